// ===== rtl/sh13_pkg.sv =====
package sh13_pkg;

	localparam int unsigned WordW     = 64;
	localparam int unsigned LenW      = 8;
	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned QueueDepth = 2;

	localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = CfgIdxW'(1);

	localparam logic [WordW-1:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [WordW-1:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [WordW-1:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [WordW-1:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [WordW-1:0] FIN_XOR = 64'h00000000000000ff;

	typedef logic [3:0][WordW-1:0] lanes_t;

	typedef struct packed {
		logic [WordW-1:0] blk;
		logic             fin;
	} item_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (WordW - n));
	endfunction

	function automatic lanes_t sip_round(input lanes_t v);
		logic [WordW-1:0] a, b, c, d;
		a = v[0];
		b = v[1];
		c = v[2];
		d = v[3];
		a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
		c = c + d; d = rotl(d, 16); d = d ^ c;
		a = a + d; d = rotl(d, 21); d = d ^ a;
		c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
		sip_round = {d, c, b, a};
	endfunction

	function automatic lanes_t sip_absorb(input lanes_t v, input logic [WordW-1:0] m);
		lanes_t t;
		t = v;
		t[3] = t[3] ^ m;
		t = sip_round(t);
		t[0] = t[0] ^ m;
		sip_absorb = t;
	endfunction

	function automatic lanes_t init_lanes(input logic [WordW-1:0] k0,
			input logic [WordW-1:0] k1);
		init_lanes = {k1 ^ SIP_C3, k0 ^ SIP_C2, k1 ^ SIP_C1, k0 ^ SIP_C0};
	endfunction

endpackage

// ===== rtl/siphash13_engine_core.sv =====
// Flow: an accepted word is queued, then absorbed into the lanes; a final item's hash is
// registered after the absorb and the three finishing rounds that follow it.
// Throughput: one word per cycle through the round unit, held by a final item's rounds.
// The queue keeps accepting until full while the round unit or result register is busy.
// Reset: keys clear to zero, lanes load from the zero key, queue and result empty.
module siphash13_engine_core #(
	parameter int unsigned QUEUE_DEPTH = sh13_pkg::QueueDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sh13_pkg::WordW-1:0]    word,
	input  logic                          is_final,
	input  logic [sh13_pkg::LenW-1:0]     length_low,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sh13_pkg::WordW-1:0]    hash_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sh13_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sh13_pkg::WordW-1:0]    cfg_data
);
	import sh13_pkg::*;

	logic   q_valid;
	item_t  q_item;
	logic   q_pop;

	sh13_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.word       (word),
		.is_final   (is_final),
		.length_low (length_low),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	sh13_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

endmodule

// ===== rtl/sh13_front.sv =====
module sh13_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sh13_pkg::WordW-1:0]  word,
	input  logic                        is_final,
	input  logic [sh13_pkg::LenW-1:0]   length_low,
	output logic                        q_valid,
	output sh13_pkg::item_t             q_item,
	input  logic                        q_pop
);
	import sh13_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	item_t            item_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             push;
	item_t            new_item;

	assign in_ready = (cnt_q != CntW'(DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = item_q[rd_q];

	always_comb begin
		new_item.fin = is_final;
		new_item.blk = is_final ? ({length_low, {(WordW - LenW){1'b0}}} | word) : word;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (q_pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	a_push_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_pop) |=> cnt_q == $past(cnt_q))
		else $error("count moved on simultaneous push and pop");

endmodule

// ===== rtl/sh13_back.sv =====
module sh13_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  sh13_pkg::item_t               q_item,
	output logic                          q_pop,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sh13_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sh13_pkg::WordW-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sh13_pkg::WordW-1:0]    hash_value
);
	import sh13_pkg::*;

	localparam logic [1:0] ST_ABSORB = 2'd0;
	localparam logic [1:0] ST_FIN1   = 2'd1;
	localparam logic [1:0] ST_FIN2   = 2'd2;
	localparam logic [1:0] ST_FIN3   = 2'd3;

	logic [1:0]        state_q;
	lanes_t            lanes_q;
	logic [WordW-1:0]  key_low_q;
	logic [WordW-1:0]  key_high_q;
	logic              out_valid_q;
	logic [WordW-1:0]  hash_q;
	lanes_t            lanes_abs;
	lanes_t            lanes_rnd;
	logic              stall;
	logic              done;
	logic              cfg_wr;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign stall      = out_valid_q && !out_ready;
	assign q_pop      = (state_q == ST_ABSORB) && q_valid;
	assign done       = (state_q == ST_FIN3) && !stall;

	always_comb begin
		lanes_abs = sip_absorb(lanes_q, q_item.blk);
		if (q_item.fin) begin
			lanes_abs[2] = lanes_abs[2] ^ FIN_XOR;
		end
		lanes_rnd = sip_round(lanes_q);
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hash_q <= lanes_rnd[0] ^ lanes_rnd[1] ^ lanes_rnd[2] ^ lanes_rnd[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ABSORB;
			key_low_q   <= '0;
			key_high_q  <= '0;
			lanes_q     <= init_lanes('0, '0);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_data;
				lanes_q   <= init_lanes(cfg_data, key_high_q);
				state_q   <= ST_ABSORB;
			end else if (cfg_wr && cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
				lanes_q    <= init_lanes(key_low_q, cfg_data);
				state_q    <= ST_ABSORB;
			end else begin
				case (state_q)
					ST_ABSORB: begin
						if (q_pop) begin
							lanes_q <= lanes_abs;
							state_q <= q_item.fin ? ST_FIN1 : ST_ABSORB;
						end
					end
					ST_FIN1: begin
						lanes_q <= lanes_rnd;
						state_q <= ST_FIN2;
					end
					ST_FIN2: begin
						lanes_q <= lanes_rnd;
						state_q <= ST_FIN3;
					end
					ST_FIN3: begin
						if (!stall) begin
							lanes_q     <= init_lanes(key_low_q, key_high_q);
							out_valid_q <= 1'b1;
							state_q     <= ST_ABSORB;
						end
					end
					default: state_q <= ST_ABSORB;
				endcase
			end
		end
	end

	a_no_pop_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ABSORB) |-> !q_pop)
		else $error("queue popped during finishing rounds");
	a_final_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.fin && !cfg_wr) |=> state_q == ST_FIN1)
		else $error("final item did not start finishing rounds");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !cfg_wr) |=> out_valid_q && state_q == ST_ABSORB)
		else $error("hash not emitted after last round");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN3 && stall && !cfg_wr) |=> state_q == ST_FIN3 && $stable(lanes_q))
		else $error("lanes moved while result blocked");

endmodule
